// ===== hw/rtl/psma_pkg.sv =====
package psma_pkg;

  // Table and window sizes
  localparam int MAX_SENSORS = 16;
  localparam int WINDOW      = 5;

  localparam int SLOT_W    = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int LOAD_W    = $clog2(MAX_SENSORS + 1);
  localparam int FILL_W    = $clog2(WINDOW + 1);
  localparam int OLD_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WIN_DEPTH = MAX_SENSORS * WINDOW;
  localparam int WADDR_W   = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

  // Window sum and reciprocal scaling for floor(sum / WINDOW)
  localparam int SUM_W   = 16 + $clog2(WINDOW);
  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint RECIP_VAL = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam longint BIAS_VAL = WINDOW * 32768;
  localparam logic [SUM_W-1:0] BIAS = SUM_W'(BIAS_VAL);

  // Operation codes
  localparam logic OP_MAP     = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_MAPPED   = 2'd0;
  localparam logic [1:0] ST_MEASURED = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [15:0]        sensor;
    logic [15:0]        room_id;
    logic signed [15:0] temperature;
    logic [31:0]        timestamp;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        echo_sensor;
    logic [15:0]        room;
    logic signed [15:0] average;
    logic               window_full;
    logic               too_cold;
    logic               too_hot;
    logic [31:0]        time_out;
  } out_t;

  // Commands to the averaging unit
  typedef struct packed {
    logic clear;
    logic add;
    logic scale;
  } avg_cmd_t;

endpackage

// ===== hw/rtl/psma_avg_unit.sv =====
module psma_avg_unit import psma_pkg::*; (
  input  logic               clk,
  input  avg_cmd_t           cmd,
  input  logic signed [15:0] sample,
  output logic signed [15:0] average
);

  logic signed [SUM_W-1:0] acc;
  logic [SUM_W-1:0]        biased;
  logic [PROD_W-1:0]       product;
  logic [15:0]             quotient;

  // Shift the sum into the non-negative range so floor division is a plain multiply
  assign biased = $unsigned(acc) + BIAS;

  // Accumulate samples, then scale by the reciprocal of the window length
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      acc <= '0;
    end else if (cmd.add) begin
      acc <= acc + SUM_W'(sample);
    end
    if (cmd.scale) begin
      product <= {{RECIP_W{1'b0}}, biased} * {{SUM_W{1'b0}}, RECIP};
    end
  end

  // Remove the bias again: it moved the quotient up by exactly 32768
  assign quotient = product[SHIFT +: 16];
  assign average  = signed'({~quotient[15], quotient[14:0]});

endmodule

// ===== hw/rtl/psma_ctrl.sv =====
module psma_ctrl import psma_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  input  logic signed [15:0] min_temp,
  input  logic signed [15:0] max_temp,
  output logic               res_valid,
  input  logic               res_ready,
  output out_t               res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state;
  in_t               item;
  logic [LOAD_W-1:0] loaded;
  logic [SLOT_W-1:0] search_idx;
  logic [SLOT_W-1:0] slot;
  logic [FILL_W-1:0] sum_k;
  logic [FILL_W-1:0] fill_count [MAX_SENSORS];
  logic [OLD_W-1:0]  oldest_slot [MAX_SENSORS];

  logic [15:0]        id_table [MAX_SENSORS];
  logic [15:0]        room_table [MAX_SENSORS];
  logic [15:0]        sample_window [WIN_DEPTH];
  logic [15:0]        id_rd;
  logic [15:0]        room_rd;
  logic signed [15:0] win_rd;

  logic               accept;
  logic               table_full;
  logic               tab_we;
  logic [SLOT_W-1:0]  tab_waddr;
  logic [SLOT_W-1:0]  id_raddr;
  logic               hit;
  logic               last_entry;
  logic [FILL_W-1:0]  fill;
  logic [OLD_W-1:0]   old;
  logic               not_full;
  logic               full_now;
  logic [WADDR_W-1:0] base;
  logic               win_we;
  logic [WADDR_W-1:0] win_waddr;
  logic [WADDR_W-1:0] win_raddr;
  avg_cmd_t           cmd;
  logic signed [15:0] average;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign table_full = (loaded == LOAD_W'(MAX_SENSORS));
  assign tab_we     = accept && (in_data.operation == OP_MAP) && !table_full;
  assign tab_waddr  = loaded[SLOT_W-1:0];

  // Read one entry ahead of the compare so the search takes one entry a cycle
  assign id_raddr   = (state == S_SRCH) ? SLOT_W'(search_idx + 1'b1) : '0;
  assign hit        = (id_rd == item.sensor);
  assign last_entry = ((LOAD_W'(search_idx) + LOAD_W'(1)) == loaded);

  // Window slot selection for the matched sensor
  assign fill      = fill_count[slot];
  assign old       = oldest_slot[slot];
  assign not_full  = (fill < FILL_W'(WINDOW));
  assign full_now  = (fill >= FILL_W'(WINDOW - 1));
  assign base      = WADDR_W'(slot * WINDOW);
  assign win_we    = (state == S_WRITE);
  assign win_waddr = base + (not_full ? WADDR_W'(fill) : WADDR_W'(old));
  assign win_raddr = base + ((sum_k < FILL_W'(WINDOW)) ? WADDR_W'(sum_k) : '0);

  // Drive the averaging unit
  always_comb begin
    cmd       = '0;
    cmd.clear = (state == S_WRITE);
    cmd.add   = (state == S_SUM) && (sum_k != '0);
    cmd.scale = (state == S_SCALE);
  end

  psma_avg_unit u_avg (
    .clk     (clk),
    .cmd     (cmd),
    .sample  (win_rd),
    .average (average)
  );

  // Id and room tables: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tab_we) begin
      id_table[tab_waddr]   <= in_data.sensor;
      room_table[tab_waddr] <= in_data.room_id;
    end
    id_rd   <= id_table[id_raddr];
    room_rd <= room_table[id_raddr];
  end

  // Sample windows of all sensors
  always_ff @(posedge clk) begin
    if (win_we) begin
      sample_window[win_waddr] <= item.temperature;
    end
    win_rd <= signed'(sample_window[win_raddr]);
  end

  // Per-sensor fill and replacement pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SENSORS; i++) begin
        fill_count[i]  <= '0;
        oldest_slot[i] <= '0;
      end
    end else if (tab_we) begin
      fill_count[tab_waddr]  <= '0;
      oldest_slot[tab_waddr] <= '0;
    end else if (win_we) begin
      if (not_full) begin
        fill_count[slot] <= fill + 1'b1;
      end else if (old == OLD_W'(WINDOW - 1)) begin
        oldest_slot[slot] <= '0;
      end else begin
        oldest_slot[slot] <= old + 1'b1;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      loaded <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DONE;
            if (in_data.operation == OP_MAP && !table_full) begin
              loaded <= loaded + 1'b1;
            end else if (in_data.operation == OP_MEASURE && loaded != '0) begin
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (hit) begin
            state <= S_WRITE;
          end else if (last_entry) begin
            state <= S_DONE;
          end
        end
        S_WRITE: state <= full_now ? S_SUM : S_DONE;
        S_SUM: begin
          if (sum_k == FILL_W'(WINDOW)) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: state <= S_CMP;
        S_CMP:   state <= S_DONE;
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item, search position and result fields
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        item        <= in_data;
        search_idx  <= '0;
        res         <= '0;
        res.echo_sensor <= in_data.sensor;
        res.time_out    <= in_data.timestamp;
        if (in_data.operation == OP_MAP) begin
          if (table_full) begin
            res.status <= ST_FULL;
          end else begin
            res.status <= ST_MAPPED;
            res.room   <= in_data.room_id;
          end
        end else begin
          res.status <= ST_UNKNOWN;
        end
      end
      S_SRCH: begin
        if (hit) begin
          slot       <= search_idx;
          res.status <= ST_MEASURED;
          res.room   <= room_rd;
        end else begin
          search_idx <= SLOT_W'(search_idx + 1'b1);
        end
      end
      S_WRITE: sum_k <= '0;
      S_SUM:   sum_k <= sum_k + 1'b1;
      S_CMP: begin
        res.average     <= average;
        res.window_full <= 1'b1;
        res.too_cold    <= (average < min_temp);
        res.too_hot     <= (average > max_temp);
      end
      S_SCALE, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/per_sensor_moving_average_alarm.sv =====
// Sensor table with a moving-average temperature alarm. A mapping request
// (operation 0) appends a sensor id and room to a table of MAX_SENSORS entries.
// A measurement request (operation 1) searches the table one entry per cycle,
// stores the reading in that sensor's window, and once the window holds WINDOW
// readings sums it through one shared accumulator, one reading per cycle, then
// scales the sum by a reciprocal multiply to get the floor average and compares
// it with min_temp and max_temp. The time a measurement takes is set by the
// linear id search and the window sum; an unknown id in an empty table skips
// both. One request is in work at a time; in_stall is high while it is. A
// finished result waits in the output register, so the next request can start
// while it is still not taken. Thresholds are to be written through the cfg
// port only while the block is idle; the user is bound by this, and the block
// itself does not enforce it. cfg_ready is always high.
module per_sensor_moving_average_alarm import psma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic signed [15:0] min_temp;
  logic signed [15:0] max_temp;
  logic               res_valid;
  logic               res_ready;
  out_t               res;

  assign cfg_ready = 1'b1;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_temp <= 16'sd3840;
      max_temp <= 16'sd6400;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_TEMP: min_temp <= signed'(cfg_data);
        CFG_MAX_TEMP: max_temp <= signed'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  psma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .min_temp  (min_temp),
    .max_temp  (max_temp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

endmodule

// ===== sim/per_sensor_moving_average_alarm_tb.sv =====
module per_sensor_moving_average_alarm_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psma_pkg::*;

  localparam int RESET_CYCLES     = 9;
  localparam int RANDOM_PER_PHASE = 210;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int DRAIN_CYCLES     = 40;
  localparam int LONG_HOLD        = 200;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  per_sensor_moving_average_alarm dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the sensor table, windows and thresholds
  logic [15:0]        shadow_id   [MAX_SENSORS];
  logic [15:0]        shadow_room [MAX_SENSORS];
  logic signed [15:0] shadow_win  [MAX_SENSORS][WINDOW];
  int                 shadow_fill [MAX_SENSORS] = '{default: 0};
  int                 shadow_next [MAX_SENSORS] = '{default: 0};
  int                 shadow_loaded = 0;
  logic signed [15:0] min_thr = 16'sd3840;
  logic signed [15:0] max_thr = 16'sd6400;

  in_t  pending_reqs[$];
  out_t expected_results[$];
  int   reqs_queued   = 0;
  int   reqs_accepted = 0;
  int   fail_count    = 0;

  // Stimulus side bookkeeping: ids that will be in the table
  logic [15:0] gen_ids[$];
  int          gen_maps = 0;

  // Work out the result of one request and advance the shadow state
  function automatic out_t predict_alarm(input in_t req);
    out_t res;
    int   slot;
    int   sum;
    int   avg;
    res = '0;
    res.echo_sensor = req.sensor;
    res.time_out    = req.timestamp;
    if (req.operation == OP_MAP) begin
      if (shadow_loaded >= MAX_SENSORS) begin
        res.status = ST_FULL;
      end else begin
        shadow_id[shadow_loaded]   = req.sensor;
        shadow_room[shadow_loaded] = req.room_id;
        shadow_fill[shadow_loaded] = 0;
        shadow_next[shadow_loaded] = 0;
        shadow_loaded++;
        res.status = ST_MAPPED;
        res.room   = req.room_id;
      end
    end else begin
      // Scan downward so the lowest matching entry wins
      slot = -1;
      for (int s = shadow_loaded - 1; s >= 0; s--) begin
        if (shadow_id[s] == req.sensor) slot = s;
      end
      if (slot < 0) begin
        res.status = ST_UNKNOWN;
      end else begin
        res.status = ST_MEASURED;
        res.room   = shadow_room[slot];
        if (shadow_fill[slot] < WINDOW) begin
          shadow_win[slot][shadow_fill[slot]] = req.temperature;
          shadow_fill[slot]++;
        end else begin
          shadow_win[slot][shadow_next[slot]] = req.temperature;
          shadow_next[slot] = (shadow_next[slot] + 1) % WINDOW;
        end
        if (shadow_fill[slot] == WINDOW) begin
          sum = 0;
          for (int k = 0; k < WINDOW; k++) sum += shadow_win[slot][k];
          // Round toward minus infinity
          avg = (sum >= 0) ? sum / WINDOW : -((-sum + WINDOW - 1) / WINDOW);
          res.average     = 16'(avg);
          res.window_full = 1'b1;
          res.too_cold    = avg < min_thr;
          res.too_hot     = avg > max_thr;
        end
      end
    end
    return res;
  endfunction

  function automatic void queue_map(input logic [15:0] id, input logic [15:0] room,
                                    input logic [31:0] ts);
    in_t req;
    req.operation   = OP_MAP;
    req.sensor      = id;
    req.room_id     = room;
    req.temperature = 16'($urandom);
    req.timestamp   = ts;
    if (gen_maps < MAX_SENSORS) gen_ids.push_back(id);
    gen_maps++;
    pending_reqs.push_back(req);
    reqs_queued++;
  endfunction

  function automatic void queue_measure(input logic [15:0] id, input logic [15:0] temp,
                                        input logic [31:0] ts);
    in_t req;
    req.operation   = OP_MEASURE;
    req.sensor      = id;
    req.room_id     = 16'($urandom);
    req.temperature = temp;
    req.timestamp   = ts;
    pending_reqs.push_back(req);
    reqs_queued++;
  endfunction

  // Mostly readings near the thresholds, some across the full range
  function automatic logic [15:0] pick_temp();
    int lo;
    int hi;
    lo = min_thr;
    hi = max_thr;
    if (max_thr < lo) lo = max_thr;
    if (min_thr > hi) hi = min_thr;
    lo -= 768;
    hi += 768;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  function automatic logic [15:0] pick_known_id();
    return gen_ids[$urandom_range(gen_ids.size() - 1)];
  endfunction

  function automatic void queue_random_phase(input int count);
    logic [15:0] id;
    int          pick;
    // Steady runs land the average exactly on each threshold
    if (gen_ids.size() > 0) begin
      id = pick_known_id();
      repeat (WINDOW) queue_measure(id, min_thr, $urandom);
      repeat (WINDOW) queue_measure(id, max_thr, $urandom);
    end
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < ((gen_maps < MAX_SENSORS) ? 12 : 3)) begin
        if (gen_ids.size() > 0 && $urandom_range(1) == 1) id = pick_known_id();
        else id = 16'($urandom);
        queue_map(id, 16'($urandom), $urandom);
      end else if (pick < 88 && gen_ids.size() > 0) begin
        queue_measure(pick_known_id(), pick_temp(), $urandom);
      end else begin
        queue_measure(16'($urandom), pick_temp(), $urandom);
      end
    end
  endfunction

  task automatic wait_drained();
    while (reqs_accepted != reqs_queued || expected_results.size() != 0) @(posedge clk);
  endtask

  // Write both thresholds while idle, then run a batch of random requests
  task automatic run_phase(input logic [15:0] lo_val, input logic [15:0] hi_val);
    cfg_index <= CFG_MIN_TEMP;
    cfg_data  <= lo_val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    min_thr = lo_val;
    cfg_index <= CFG_MAX_TEMP;
    cfg_data  <= hi_val;
    do @(posedge clk); while (!cfg_ready);
    max_thr = hi_val;
    cfg_valid <= 1'b0;
    queue_random_phase(RANDOM_PER_PHASE);
    wait_drained();
  endtask

  task automatic check_result(input out_t got, input out_t exp);
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      fail_count++;
    end
    if (got.echo_sensor !== exp.echo_sensor) begin
      $error("echo_sensor: expected %h, got %h", exp.echo_sensor, got.echo_sensor);
      fail_count++;
    end
    if (got.room !== exp.room) begin
      $error("room: expected %h, got %h", exp.room, got.room);
      fail_count++;
    end
    if (got.average !== exp.average) begin
      $error("average: expected %0d, got %0d", exp.average, got.average);
      fail_count++;
    end
    if (got.window_full !== exp.window_full) begin
      $error("window_full: expected %0b, got %0b", exp.window_full, got.window_full);
      fail_count++;
    end
    if (got.too_cold !== exp.too_cold) begin
      $error("too_cold: expected %0b, got %0b", exp.too_cold, got.too_cold);
      fail_count++;
    end
    if (got.too_hot !== exp.too_hot) begin
      $error("too_hot: expected %0b, got %0b", exp.too_hot, got.too_hot);
      fail_count++;
    end
    if (got.time_out !== exp.time_out) begin
      $error("time_out: expected %h, got %h", exp.time_out, got.time_out);
      fail_count++;
    end
  endtask

  // Request driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_alarm(in_data));
        reqs_accepted++;
      end
      // Hold a stalled request, otherwise advance
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(80, 20) : $urandom_range(12);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(15, 1);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall pattern
  rx_mode_t rx_mode       = RX_FREE;
  int       rx_left       = 0;
  int       hold_left     = 0;
  int       results_taken = 0;

  always @(posedge clk) begin
    logic stall_next;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_taken++;
        if (expected_results.size() == 0) begin
          $error("result with no request pending: sensor %h", out_data.echo_sensor);
          fail_count++;
        end else begin
          check_result(out_data, expected_results.pop_front());
        end
        // Hold off long enough for the block to back up into its input
        if (results_taken == 250 || results_taken == 1000) hold_left = LONG_HOLD;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(3));
        rx_left = $urandom_range(60, 5);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_FREE:  stall_next = 1'b0;
        RX_LIGHT: stall_next = $urandom_range(9) < 3;
        RX_HEAVY: stall_next = $urandom_range(9) < 7;
        default:  stall_next = ~out_stall;
      endcase
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end
      out_stall <= stall_next;
    end
  end

  // Run limit
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int band_lo;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Unknown sensor while the table is still empty
    queue_measure(16'h1234, 16'sd100, 32'h0000_0000);
    // Extreme ids and rooms, then a duplicate id
    queue_map(16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    queue_map(16'hFFFF, 16'h0000, 32'h0000_0000);
    queue_map(16'h0000, 16'h1111, 32'h8000_0001);
    // Fill a window at the top of the range, then push it to the bottom
    repeat (WINDOW) queue_measure(16'h0000, 16'sh7FFF, 32'hFFFF_FFFF);
    repeat (WINDOW) queue_measure(16'h0000, 16'sh8000, 32'h0000_0000);
    // Average equal to the lower threshold, then one step below it
    repeat (WINDOW) queue_measure(16'hFFFF, 16'sd3840, 32'h7FFF_FFFF);
    queue_measure(16'hFFFF, 16'sd3839, 32'h5555_AAAA);
    // Unknown sensor with entries loaded
    queue_measure(16'h0001, 16'sd0, 32'hAAAA_5555);
    queue_random_phase(RANDOM_PER_PHASE);
    wait_drained();

    run_phase(16'h8000, 16'h7FFF);
    run_phase(16'h7FFF, 16'h8000);
    run_phase(16'h0000, 16'h0000);
    run_phase(16'($urandom), 16'($urandom));
    band_lo = int'($urandom_range(16000)) - 8000;
    run_phase(16'(band_lo), 16'(band_lo + int'($urandom_range(4000))));
    run_phase(16'd3840, 16'd6400);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
